>>> hdl/range_partitioned_sorted_search_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range partitioned sorted search block
// Same-cycle and next-cycle implications, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_PARTITIONED_SORTED_SEARCH_ASSERT_SVH
`define RANGE_PARTITIONED_SORTED_SEARCH_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RPSS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpss assertion failed");

// antecedent implies consequent in the next cycle
`define RPSS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpss assertion failed");

`endif

>>> hdl/rpss_pkg.sv
// ----------------------------------------------------------------------------
// rpss_pkg
// Constants, request codes and beat types of the range partitioned search.
// ----------------------------------------------------------------------------
package rpss_pkg;

   localparam int NUM_SEGMENTS = 5;
   localparam int SEG_DEPTH    = 512;

   localparam int CODE_W      = 16;
   localparam int SEG_W       = 3;
   localparam int LEN_W       = 10;
   localparam int POS_W       = 9;
   localparam int CNT_W       = $clog2(SEG_DEPTH + 1);
   localparam int IDX_W       = $clog2(SEG_DEPTH);
   localparam int STORE_DEPTH = NUM_SEGMENTS * SEG_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [1:0] REQ_DESC   = 2'd0;
   localparam logic [1:0] REQ_WORD   = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [SEG_W-1:0]  seg_index;
      logic [CODE_W-1:0] range_low;
      logic [CODE_W-1:0] range_high;
      logic [LEN_W-1:0]  seg_length;
      logic [POS_W-1:0]  entry_pos;
      logic [CODE_W-1:0] entry_code;
      logic [CODE_W-1:0] code_point;
   } rpss_req_type;

   typedef struct packed {
      logic             found;
      logic [SEG_W-1:0] segment;
      logic [POS_W-1:0] position;
   } rpss_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SEARCH = 2'b10
   } rpss_state_type;

endpackage

>>> hdl/rpss_ram.sv
// ----------------------------------------------------------------------------
// rpss_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rpss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/range_partitioned_sorted_search.sv
// Lookup: the result strobe follows the table probes, P of them, at most
//   ceil(log2(SEG_DEPTH+1)) (10 for 512 words); a code outside every range or an
//   empty segment answers without a probe, from the result register.
// Probe rate is one per cycle, set by the single registered read port of the table RAM.
// Loads leave the block idle and give no result. busy falls in the result cycle.
// Reset empties all segment ranges and counts; the table RAM is not cleared.
// ----------------------------------------------------------------------------
// range_partitioned_sorted_search
// Picks the first segment whose code range holds the key, then binary searches
// that segment's sorted table in RAM, one probe per cycle.
// ----------------------------------------------------------------------------
module range_partitioned_sorted_search
   import rpss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  rpss_req_type req_data,
   output logic         rsp_valid,
   output rpss_rsp_type rsp_data
);

   // segment descriptors
   logic [CODE_W-1:0] low_ff  [NUM_SEGMENTS];
   logic [CODE_W-1:0] high_ff [NUM_SEGMENTS];
   logic [CNT_W-1:0]  cnt_ff  [NUM_SEGMENTS];
   logic [CODE_W-1:0] low_in  [NUM_SEGMENTS];
   logic [CODE_W-1:0] high_in [NUM_SEGMENTS];
   logic [CNT_W-1:0]  cnt_in  [NUM_SEGMENTS];

   rpss_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  ub_ff, ub_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic [CODE_W-1:0] key_ff, key_in;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rpss_rsp_type      rsp_ff, rsp_in;

   logic              accept;
   logic              hit;
   logic [SEG_W-1:0]  sel;
   logic [CNT_W-1:0]  sel_cnt;
   logic [CNT_W-1:0]  len_sat;
   logic [CNT_W-1:0]  lo_n, ub_n;
   logic [CNT_W:0]    mid_sum;
   logic              key_lt, key_gt;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [CODE_W-1:0] rd_data;

   function automatic logic [IDX_W-1:0] midpoint(input logic [CNT_W-1:0] lo,
                                                 input logic [CNT_W-1:0] ub);
      logic [CNT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, ub} - {{CNT_W{1'b0}}, 1'b1};
      return IDX_W'(sum >> 1);
   endfunction

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // first segment, in index order, whose range holds the key
   always_comb begin
      hit     = 1'b0;
      sel     = '0;
      sel_cnt = '0;
      for (int i = NUM_SEGMENTS - 1; i >= 0; i--) begin
         if (low_ff[i] <= req_data.code_point && req_data.code_point <= high_ff[i]) begin
            hit     = 1'b1;
            sel     = SEG_W'(i);
            sel_cnt = cnt_ff[i];
         end
      end
   end

   assign len_sat = (int'(req_data.seg_length) > SEG_DEPTH) ? CNT_W'(SEG_DEPTH)
                                                            : CNT_W'(req_data.seg_length);

   assign key_lt  = key_ff < rd_data;
   assign key_gt  = key_ff > rd_data;
   assign lo_n    = key_gt ? CNT_W'(mid_ff) + CNT_W'(1) : lo_ff;
   assign ub_n    = key_lt ? CNT_W'(mid_ff) : ub_ff;
   assign mid_sum = {1'b0, lo_n} + {1'b0, ub_n};

   assign wr_addr = ADDR_W'(int'(req_data.seg_index) * SEG_DEPTH + int'(req_data.entry_pos));

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      ub_in        = ub_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      seg_in       = seg_ff;
      base_in      = base_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      rd_addr      = base_ff + ADDR_W'(mid_ff);
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
         low_in[i]  = low_ff[i];
         high_in[i] = high_ff[i];
         cnt_in[i]  = cnt_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_DESC: begin
                     for (int i = 0; i < NUM_SEGMENTS; i++) begin
                        if (int'(req_data.seg_index) == i) begin
                           low_in[i]  = req_data.range_low;
                           high_in[i] = req_data.range_high;
                           cnt_in[i]  = len_sat;
                        end
                     end
                  end
                  REQ_WORD: begin
                     wr_en = (int'(req_data.seg_index) < NUM_SEGMENTS) &&
                             (int'(req_data.entry_pos) < SEG_DEPTH);
                  end
                  REQ_LOOKUP: begin
                     key_in  = req_data.code_point;
                     seg_in  = sel;
                     base_in = ADDR_W'(int'(sel) * SEG_DEPTH);
                     lo_in   = '0;
                     ub_in   = sel_cnt;
                     mid_in  = midpoint('0, sel_cnt);
                     rd_addr = ADDR_W'(int'(sel) * SEG_DEPTH) + ADDR_W'(mid_in);
                     if (hit && sel_cnt != '0) begin
                        state_in = ST_SEARCH;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // rd_data holds the word at mid_ff
            if (!key_lt && !key_gt) begin
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b1;
               rsp_in.segment  = seg_ff;
               rsp_in.position = POS_W'(mid_ff);
            end else if (lo_n >= ub_n) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
            end else begin
               lo_in   = lo_n;
               ub_in   = ub_n;
               mid_in  = IDX_W'((mid_sum - (CNT_W + 1)'(1)) >> 1);
               rd_addr = base_ff + ADDR_W'(mid_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SEGMENTS; i++) begin
            low_ff[i]  <= '1;
            high_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_SEGMENTS; i++) begin
            low_ff[i]  <= low_in[i];
            high_ff[i] <= high_in[i];
            cnt_ff[i]  <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      ub_ff   <= ub_in;
      mid_ff  <= mid_in;
      key_ff  <= key_in;
      seg_ff  <= seg_in;
      base_ff <= base_in;
      rsp_ff  <= rsp_in;
   end

   rpss_ram #(
      .WIDTH (CODE_W),
      .DEPTH (STORE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.entry_code),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/rpss_checker.sv
// ----------------------------------------------------------------------------
// rpss_checker
// Port-level checks of the range partitioned search, bound to the top level.
// ----------------------------------------------------------------------------
`include "range_partitioned_sorted_search_assert.svh"

module rpss_checker
   import rpss_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input rpss_req_type req_data,
   input logic         rsp_valid,
   input rpss_rsp_type rsp_data
);

   logic lookup_beat;
   logic load_beat;
   logic hit_beat;
   logic miss_beat;
   logic miss_zero;

   assign lookup_beat = start && !busy && req_data.req_type == REQ_LOOKUP;
   assign load_beat   = start && !busy && req_data.req_type != REQ_LOOKUP;
   assign hit_beat    = rsp_valid && rsp_data.found;
   assign miss_beat   = rsp_valid && !rsp_data.found;
   assign miss_zero   = rsp_data.segment == '0 && rsp_data.position == '0;

   // a lookup beat either answers at once or keeps the block searching
   `RPSS_ASSERT_NXT(a_lookup_progress, clock, reset, lookup_beat, busy || rsp_valid)

   // load beats never produce a result
   `RPSS_ASSERT_NXT(a_load_silent, clock, reset, load_beat, !rsp_valid)

   // a result always ends the search
   `RPSS_ASSERT_IMP(a_result_idle, clock, reset, rsp_valid, !busy)

   // a miss reports segment and position as zero
   `RPSS_ASSERT_IMP(a_miss_zero, clock, reset, miss_beat, miss_zero)

   // a hit names a segment that exists
   `RPSS_ASSERT_IMP(a_hit_segment, clock, reset, hit_beat, int'(rsp_data.segment) < NUM_SEGMENTS)

endmodule

bind range_partitioned_sorted_search rpss_checker u_rpss_checker (.*);

>>> tb/tb_range_partitioned_sorted_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_partitioned_sorted_search
// Loads segment descriptors and sorted code tables, then looks up code points
// and checks every result beat against a local range-select plus binary-search
// predictor. The sender runs in random bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_range_partitioned_sorted_search
   import rpss_pkg::*;
();

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int         TARGET_BEATS = 950;
   localparam int         SETTLE_CYCLES = 40;

   typedef struct {
      rpss_req_type beat;
      bit           drain;   // hold this beat until all lookups have answered
   } req_item_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   rpss_req_type req_data;
   logic         rsp_valid;
   rpss_rsp_type rsp_data;

   range_partitioned_sorted_search u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   req_item_type req_beats[$];
   rpss_rsp_type expected_answers[$];

   // predictor copy of the block state
   logic [CODE_W-1:0] pred_lo  [8] = '{default: '1};
   logic [CODE_W-1:0] pred_hi  [8] = '{default: '0};
   int                pred_cnt [8] = '{default: 0};
   logic [CODE_W-1:0] pred_tab [STORE_DEPTH];

   // stimulus-side shadow, used to aim lookups and to keep reads on written words
   logic [CODE_W-1:0] gen_lo   [NUM_SEGMENTS];
   logic [CODE_W-1:0] gen_hi   [NUM_SEGMENTS];
   int                gen_cnt  [NUM_SEGMENTS];
   int                gen_fill [NUM_SEGMENTS];
   logic [CODE_W-1:0] gen_tab  [NUM_SEGMENTS][SEG_DEPTH];

   int   issued_beats;
   int   err_count = 0;
   int   lookups_checked = 0;
   int   found_count = 0;
   int   load_count = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   logic beat_taken = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout at %0t", $time);
      $display("range_partitioned_sorted_search: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic rpss_rsp_type search_tables(input logic [CODE_W-1:0] key);
      rpss_rsp_type      r;
      int                lo_i;
      int                hi_i;
      int                mid;
      logic [CODE_W-1:0] probe;
      r = '0;
      for (int s = 0; s < NUM_SEGMENTS; s++) begin
         if (pred_lo[s] <= key && key <= pred_hi[s]) begin
            lo_i = 0;
            hi_i = pred_cnt[s] - 1;
            while (hi_i >= lo_i) begin
               mid   = (lo_i + hi_i) / 2;
               probe = pred_tab[s * SEG_DEPTH + mid];
               if (key < probe) begin
                  hi_i = mid - 1;
               end else if (key > probe) begin
                  lo_i = mid + 1;
               end else begin
                  r.found    = 1'b1;
                  r.segment  = s[SEG_W-1:0];
                  r.position = mid[POS_W-1:0];
                  break;
               end
            end
            break;  // first matching range wins, hit or miss
         end
      end
      return r;
   endfunction

   task automatic apply_beat(input rpss_req_type b);
      int len;
      case (b.req_type)
         REQ_DESC: begin
            if (b.seg_index < NUM_SEGMENTS) begin
               len = (b.seg_length > SEG_DEPTH) ? SEG_DEPTH : int'(b.seg_length);
               pred_lo[b.seg_index]  = b.range_low;
               pred_hi[b.seg_index]  = b.range_high;
               pred_cnt[b.seg_index] = len;
               load_count++;
            end
         end
         REQ_WORD: begin
            if (b.seg_index < NUM_SEGMENTS && b.entry_pos < SEG_DEPTH) begin
               pred_tab[int'(b.seg_index) * SEG_DEPTH + int'(b.entry_pos)] = b.entry_code;
               load_count++;
            end
         end
         REQ_LOOKUP: expected_answers.push_back(search_tables(b.code_point));
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus
   function automatic rpss_req_type rand_beat(input logic [1:0] kind);
      rpss_req_type b;
      b.req_type   = kind;
      b.seg_index  = SEG_W'($urandom);
      b.range_low  = CODE_W'($urandom);
      b.range_high = CODE_W'($urandom);
      b.seg_length = LEN_W'($urandom);
      b.entry_pos  = POS_W'($urandom);
      b.entry_code = CODE_W'($urandom);
      b.code_point = CODE_W'($urandom);
      return b;
   endfunction

   task automatic queue_beat(input rpss_req_type b, input bit drain);
      req_item_type it;
      it.beat  = b;
      it.drain = drain;
      req_beats.push_back(it);
      if (b.req_type == REQ_LOOKUP) begin
         issued_beats++;
      end else if (b.seg_index < NUM_SEGMENTS && b.req_type == REQ_DESC) begin
         gen_lo[b.seg_index]  = b.range_low;
         gen_hi[b.seg_index]  = b.range_high;
         gen_cnt[b.seg_index] = (b.seg_length > SEG_DEPTH) ? SEG_DEPTH : int'(b.seg_length);
         issued_beats++;
      end else if (b.seg_index < NUM_SEGMENTS && b.req_type == REQ_WORD) begin
         gen_tab[b.seg_index][b.entry_pos] = b.entry_code;
         issued_beats++;
      end
   endtask

   task automatic queue_word(input int s, input int p, input logic [CODE_W-1:0] code);
      rpss_req_type b;
      b            = rand_beat(REQ_WORD);
      b.seg_index  = s[SEG_W-1:0];
      b.entry_pos  = p[POS_W-1:0];
      b.entry_code = code;
      queue_beat(b, 1'b0);
   endtask

   task automatic queue_desc(input int s, input int lo, input int hi, input int len);
      rpss_req_type b;
      b            = rand_beat(REQ_DESC);
      b.seg_index  = s[SEG_W-1:0];
      b.range_low  = lo[CODE_W-1:0];
      b.range_high = hi[CODE_W-1:0];
      b.seg_length = len[LEN_W-1:0];
      queue_beat(b, 1'b0);
   endtask

   task automatic queue_lookup(input int key, input bit drain);
      rpss_req_type b;
      b            = rand_beat(REQ_LOOKUP);
      b.code_point = key[CODE_W-1:0];
      queue_beat(b, drain);
   endtask

   // writes positions 0..n-1, ascending with occasional repeats, or scrambled
   task automatic load_table(input int s, input int n, input bit scrambled);
      int step_max;
      int v;
      step_max = (n > 0) ? 60000 / n : 1;
      if (step_max > 3000) step_max = 3000;
      v = $urandom_range(0, 65535 - step_max * n);
      for (int p = 0; p < n; p++) begin
         queue_word(s, p, scrambled ? CODE_W'($urandom) : v[CODE_W-1:0]);
         v += $urandom_range(0, step_max);
      end
      if (n > gen_fill[s]) gen_fill[s] = n;
   endtask

   task automatic reconfigure(input int s);
      int len;
      int n;
      int lo;
      int hi;
      if (s == NUM_SEGMENTS - 1 && $urandom_range(0, 2) == 0) begin
         len = $urandom_range(0, 1023);
      end else if ($urandom_range(0, 9) == 0) begin
         len = 0;
      end else if ($urandom_range(0, 4) == 0) begin
         len = $urandom_range(17, 48);
      end else begin
         len = $urandom_range(1, 16);
      end
      n = (len > SEG_DEPTH) ? SEG_DEPTH : len;
      if (n > gen_fill[s] || (n <= 48 && $urandom_range(0, 1) == 0))
         load_table(s, n, $urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
         6: begin
            lo = 0;
            hi = 65535;
         end
         7, 8: begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(0, 65535);
         end
         9: begin
            lo = $urandom_range(1, 65535);
            hi = lo - 1;
         end
         default: begin
            if (n > 0) begin
               lo = int'(gen_tab[s][0]) - $urandom_range(0, 40);
               hi = int'(gen_tab[s][n-1]) + $urandom_range(0, 40);
               if (lo < 0) lo = 0;
               if (hi > 65535) hi = 65535;
            end else begin
               lo = $urandom_range(0, 65535);
               hi = $urandom_range(0, 65535);
            end
         end
      endcase
      queue_desc(s, lo, hi, len);
   endtask

   function automatic int pick_key();
      int s;
      int k;
      s = $urandom_range(0, NUM_SEGMENTS - 1);
      k = $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            if (gen_cnt[s] != 0) begin
               k = int'(gen_tab[s][$urandom_range(0, gen_cnt[s] - 1)]);
               if ($urandom_range(0, 4) == 0) k = k + 1 - 2 * $urandom_range(0, 1);
            end
         end
         5, 6: if (gen_lo[s] <= gen_hi[s]) k = $urandom_range(gen_lo[s], gen_hi[s]);
         8: k = $urandom_range(0, 1) ? 65535 : 0;
         9: k = ($urandom_range(0, 1) ? int'(gen_lo[s]) : int'(gen_hi[s]))
                + $urandom_range(0, 2) - 1;
         default: ;
      endcase
      return k & 16'hFFFF;
   endfunction

   task automatic queue_noise();
      rpss_req_type b;
      int s;
      case ($urandom_range(0, 3))
         0: begin
            b           = rand_beat(REQ_DESC);
            b.seg_index = SEG_W'($urandom_range(NUM_SEGMENTS, 7));
            queue_beat(b, 1'b0);
         end
         1: begin
            b           = rand_beat(REQ_WORD);
            b.seg_index = SEG_W'($urandom_range(NUM_SEGMENTS, 7));
            queue_beat(b, 1'b0);
         end
         2: queue_beat(rand_beat(REQ_UNUSED), 1'b0);
         default: begin
            // overwrite an already written word: table may become unsorted
            s = $urandom_range(0, NUM_SEGMENTS - 1);
            if (gen_fill[s] != 0)
               queue_word(s, $urandom_range(0, gen_fill[s] - 1), CODE_W'($urandom));
         end
      endcase
   endtask

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else if (!(start && !beat_taken)) begin
         if (gap_left != 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (req_beats.size() == 0 ||
                      (req_beats[0].drain && (expected_answers.size() != 0 || busy))) begin
            start <= 1'b0;
         end else begin
            start    <= 1'b1;
            req_data <= req_beats[0].beat;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                        : $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      rpss_rsp_type want;
      beat_taken <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               err_count++;
               $display("%0t unexpected result beat: found=%0d seg=%0d pos=%0d", $time,
                        rsp_data.found, rsp_data.segment, rsp_data.position);
            end else begin
               want = expected_answers.pop_front();
               lookups_checked++;
               if (want.found) found_count++;
               if (rsp_data.found !== want.found || rsp_data.segment !== want.segment ||
                   rsp_data.position !== want.position) begin
                  err_count++;
                  $display("%0t expected found=%0d seg=%0d pos=%0d, %s", $time,
                           want.found, want.segment, want.position, "got");
                  $display("%0t    actual found=%0d seg=%0d pos=%0d", $time,
                           rsp_data.found, rsp_data.segment, rsp_data.position);
               end
            end
         end
         if (start && !busy) begin
            apply_beat(req_data);
            void'(req_beats.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------- main
   initial begin
      int round;
      reset        = 1'b1;
      issued_beats = 0;
      for (int s = 0; s < NUM_SEGMENTS; s++) begin
         gen_lo[s]   = '1;
         gen_hi[s]   = '0;
         gen_cnt[s]  = 0;
         gen_fill[s] = 0;
      end

      // directed: empty state, extremes, empty segment, shadowing, ignored beats
      queue_lookup(16'h0000, 1'b0);
      queue_lookup(16'hFFFF, 1'b0);
      queue_word(0, 0, 16'h0000);
      queue_word(0, 1, 16'hFFFF);
      gen_fill[0] = 2;
      queue_desc(0, 16'h0000, 16'hFFFF, 0);
      queue_lookup(16'h0000, 1'b0);
      queue_desc(0, 16'h0000, 16'hFFFF, 2);
      queue_lookup(16'h0000, 1'b0);
      queue_lookup(16'hFFFF, 1'b0);
      queue_lookup(16'h1234, 1'b0);
      queue_word(1, 0, 16'h1234);
      gen_fill[1] = 1;
      queue_desc(1, 16'h1000, 16'h1FFF, 1);
      queue_lookup(16'h1234, 1'b0);   // segment 0 wins and misses
      queue_desc(0, 16'h0000, 16'h0000, 2);
      queue_lookup(16'h1234, 1'b0);
      queue_desc(7, 16'h0000, 16'hFFFF, 1);
      queue_word(NUM_SEGMENTS, 0, 16'h4321);
      queue_beat(rand_beat(REQ_UNUSED), 1'b0);
      queue_lookup(16'h1234, 1'b1);
      queue_word(1, 0, 16'hFFFF);
      queue_lookup(16'h1234, 1'b0);
      queue_lookup(16'hFFFF, 1'b0);

      // one full-depth table, then a saturating length on it
      load_table(NUM_SEGMENTS - 1, SEG_DEPTH, 1'b0);
      queue_desc(NUM_SEGMENTS - 1, 0, 65535, 1023);
      for (int i = 0; i < 12; i++) queue_lookup(pick_key(), 1'b0);

      round = 0;
      while (issued_beats < TARGET_BEATS) begin
         repeat ($urandom_range(1, 2)) reconfigure($urandom_range(0, NUM_SEGMENTS - 1));
         if ($urandom_range(0, 3) == 0) queue_noise();
         repeat ($urandom_range(4, 16)) queue_lookup(pick_key(), 1'b0);
         if ($urandom_range(0, 4) == 0) queue_noise();
         round++;
         if (round % 6 == 0) queue_lookup(pick_key(), 1'b1);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (req_beats.size() != 0 || expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d load beats and %0d lookups (%0d found, %0d not found),",
               load_count, lookups_checked, found_count, lookups_checked - found_count);
      $display("including a full-depth table, empty and shadowed segments, ignored beats.");
      if (err_count == 0 && expected_answers.size() == 0) begin
         $display("range_partitioned_sorted_search: match");
      end else begin
         $display("range_partitioned_sorted_search: mismatch");
      end
      $finish;
   end

endmodule
